// ----- rtl/bee_pkg.sv -----
// ----------------------------------------------------------------------------
// Boolean expression equivalence package
// Shared item types, command codes, character constants and operator precedence.
// ----------------------------------------------------------------------------
package bee_pkg;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic       equivalent;
    logic       error;
    logic [4:0] variable_count;
  } out_item_t;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND1 = 2'd1;
  localparam logic [1:0] OP_APPEND2 = 2'd2;
  localparam logic [1:0] OP_RUN     = 2'd3;

  localparam logic [7:0] CH_NOT  = 8'h7E;
  localparam logic [7:0] CH_AND  = 8'h26;
  localparam logic [7:0] CH_XOR  = 8'h5E;
  localparam logic [7:0] CH_OR   = 8'h7C;
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_A    = 8'h61;

  function automatic logic [2:0] prec(input logic [7:0] c);
    case (c)
      CH_NOT:  prec = 3'd4;
      CH_AND:  prec = 3'd3;
      CH_XOR:  prec = 3'd2;
      CH_OR:   prec = 3'd1;
      default: prec = 3'd0;
    endcase
  endfunction

endpackage

// ----- rtl/bee_front.sv -----
// ----------------------------------------------------------------------------
// Command front end
// Takes commands, stores both expression texts and their lengths, and
// starts the back end on a run command.
// ----------------------------------------------------------------------------
module bee_front import bee_pkg::*; #(
  parameter int MAX_LEN = 128,
  parameter int AW      = $clog2(MAX_LEN),
  parameter int LW      = $clog2(MAX_LEN + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  in_item_t      item,
  input  logic          rd_sel,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  output logic [LW-1:0] len1,
  output logic [LW-1:0] len2,
  output logic          ovf,
  output logic          start
);

  logic [7:0]    text1 [MAX_LEN];
  logic [7:0]    text2 [MAX_LEN];
  logic [LW-1:0] len1_r, len2_r;
  logic          ovf_r;
  logic [7:0]    rd1_r, rd2_r;
  logic          sel_r;
  logic          wr1, wr2;

  assign wr1 = acc && (item.operation == OP_APPEND1) && (len1_r < LW'(MAX_LEN));
  assign wr2 = acc && (item.operation == OP_APPEND2) && (len2_r < LW'(MAX_LEN));

  always_ff @(posedge clk) begin
    if (wr1) begin
      text1[len1_r[AW-1:0]] <= item.symbol;
    end
    if (wr2) begin
      text2[len2_r[AW-1:0]] <= item.symbol;
    end
    rd1_r <= text1[rd_addr];
    rd2_r <= text2[rd_addr];
    sel_r <= rd_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len1_r <= '0;
      len2_r <= '0;
      ovf_r  <= 1'b0;
    end else if (acc) begin
      case (item.operation)
        OP_CLEAR: begin
          len1_r <= '0;
          len2_r <= '0;
          ovf_r  <= 1'b0;
        end
        OP_APPEND1: begin
          if (wr1) len1_r <= len1_r + LW'(1);
          else     ovf_r  <= 1'b1;
        end
        OP_APPEND2: begin
          if (wr2) len2_r <= len2_r + LW'(1);
          else     ovf_r  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign rd_data = sel_r ? rd2_r : rd1_r;
  assign len1    = len1_r;
  assign len2    = len2_r;
  assign ovf     = ovf_r;
  assign start   = acc && (item.operation == OP_RUN);

endmodule

// ----- rtl/bee_back.sv -----
// ----------------------------------------------------------------------------
// Conversion and evaluation engine
// Validates both texts, converts them to postfix with an operator stack and
// evaluates them under every assignment with a value stack.
// ----------------------------------------------------------------------------
module bee_back import bee_pkg::*; #(
  parameter int MAX_LEN  = 128,
  parameter int NUM_VARS = 26,
  parameter int AW       = $clog2(MAX_LEN),
  parameter int LW       = $clog2(MAX_LEN + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          ovf,
  input  logic [LW-1:0] len1,
  input  logic [LW-1:0] len2,
  output logic          txt_sel,
  output logic [AW-1:0] txt_addr,
  input  logic [7:0]    txt_data,
  output logic          busy,
  output logic          res_push,
  input  logic          res_full,
  output out_item_t     res
);

  localparam int PW = $clog2(2 * MAX_LEN);
  localparam int RW = $clog2(NUM_VARS + 1);
  localparam int VW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int CW = NUM_VARS + 1;
  localparam logic [7:0] VAR_END = 8'(97 + NUM_VARS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CREAD = 4'd1;
  localparam logic [3:0] S_CCHAR = 4'd2;
  localparam logic [3:0] S_CBIN  = 4'd3;
  localparam logic [3:0] S_CRPAR = 4'd4;
  localparam logic [3:0] S_CEND  = 4'd5;
  localparam logic [3:0] S_WAIT  = 4'd6;
  localparam logic [3:0] S_RANK  = 4'd7;
  localparam logic [3:0] S_EREAD = 4'd8;
  localparam logic [3:0] S_ETOK  = 4'd9;
  localparam logic [3:0] S_EDONE = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0]    state_r, state_nxt, ret_r, ret_nxt;
  logic          sel_r, sel_nxt;
  logic [LW-1:0] idx_r, idx_nxt, top_r, top_nxt, depth_r, depth_nxt;
  logic [LW-1:0] n_r, n_nxt, sp_r, sp_nxt;
  logic [LW-1:0] plen0_r, plen0_nxt, plen1_r, plen1_nxt;
  logic          want_r, want_nxt;
  logic [7:0]    cur_r, cur_nxt;
  logic [NUM_VARS-1:0] mask_r, mask_nxt;
  logic [RW-1:0] k_r, k_nxt, cnt_r, cnt_nxt;
  logic [CW-1:0] asg_r, asg_nxt;
  logic          tv_r, tv_nxt, res0_r, res0_nxt;
  logic          err_r, err_nxt, eq_r, eq_nxt;
  logic [RW-1:0] rank_r [NUM_VARS];
  logic          rank_we;

  logic [7:0]    opstk [MAX_LEN];
  logic [7:0]    post  [2*MAX_LEN];
  logic          vstk  [MAX_LEN];
  logic [7:0]    op_rd_r, post_rd_r;
  logic          vs_rd_r;

  logic          op_we, post_we, vs_we;
  logic [7:0]    op_wdata, post_wdata;
  logic [PW-1:0] post_waddr, post_raddr;
  logic [AW-1:0] op_raddr, vs_raddr, vs_waddr;

  logic [7:0]    c;
  logic          c_var, c_opnd;
  logic [VW-1:0] c_idx;
  logic [LW-1:0] cur_len, cur_plen;
  logic          opnd_val;

  // Pops at the operator stack go to the postfix store of the current text.
  assign post_waddr = PW'(n_r) + (sel_r ? PW'(MAX_LEN) : PW'(0));
  assign post_raddr = PW'(idx_r) + (sel_r ? PW'(MAX_LEN) : PW'(0));
  assign op_raddr   = AW'(top_r - LW'(1));
  assign vs_raddr   = AW'(sp_r - LW'(2));
  assign vs_waddr   = AW'(sp_r - LW'(1));

  always_ff @(posedge clk) begin
    if (op_we) begin
      opstk[top_r[AW-1:0]] <= op_wdata;
    end
    if (post_we) begin
      post[post_waddr] <= post_wdata;
    end
    if (vs_we) begin
      vstk[vs_waddr] <= tv_r;
    end
    op_rd_r   <= opstk[op_raddr];
    post_rd_r <= post[post_raddr];
    vs_rd_r   <= vstk[vs_raddr];
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_r[k_r[VW-1:0]] <= cnt_r;
    end
  end

  assign c        = (state_r == S_ETOK) ? post_rd_r : txt_data;
  assign c_var    = (c >= CH_A) && (c < VAR_END);
  assign c_opnd   = c_var || (c == CH_ZERO) || (c == CH_ONE);
  assign c_idx    = VW'(c - CH_A);
  assign cur_len  = sel_r ? len2 : len1;
  assign cur_plen = sel_r ? plen1_r : plen0_r;
  assign opnd_val = c_var ? asg_r[rank_r[c_idx]] : (c == CH_ONE);

  assign txt_sel  = sel_r;
  assign txt_addr = idx_r[AW-1:0];

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    sel_nxt    = sel_r;
    idx_nxt    = idx_r;
    top_nxt    = top_r;
    depth_nxt  = depth_r;
    n_nxt      = n_r;
    sp_nxt     = sp_r;
    plen0_nxt  = plen0_r;
    plen1_nxt  = plen1_r;
    want_nxt   = want_r;
    cur_nxt    = cur_r;
    mask_nxt   = mask_r;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    asg_nxt    = asg_r;
    tv_nxt     = tv_r;
    res0_nxt   = res0_r;
    err_nxt    = err_r;
    eq_nxt     = eq_r;
    rank_we    = 1'b0;
    op_we      = 1'b0;
    op_wdata   = c;
    post_we    = 1'b0;
    post_wdata = c;
    vs_we      = 1'b0;
    res_push   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          err_nxt   = ovf;
          eq_nxt    = 1'b0;
          mask_nxt  = '0;
          sel_nxt   = 1'b0;
          idx_nxt   = '0;
          top_nxt   = '0;
          depth_nxt = '0;
          n_nxt     = '0;
          want_nxt  = 1'b1;
          state_nxt = ovf ? S_FIN : S_CREAD;
        end
      end
      S_CREAD: begin
        state_nxt = (idx_r == cur_len) ? S_CEND : S_CCHAR;
      end
      S_CCHAR: begin
        cur_nxt = c;
        if (c_opnd) begin
          if (!want_r) begin
            err_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            if (c_var) mask_nxt[c_idx] = 1'b1;
            post_we   = 1'b1;
            n_nxt     = n_r + LW'(1);
            want_nxt  = 1'b0;
            idx_nxt   = idx_r + LW'(1);
            state_nxt = S_CREAD;
          end
        end else if (c == CH_LPAR || c == CH_NOT) begin
          if (!want_r || top_r >= LW'(MAX_LEN)) begin
            err_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            if (c == CH_LPAR) depth_nxt = depth_r + LW'(1);
            op_we     = 1'b1;
            top_nxt   = top_r + LW'(1);
            idx_nxt   = idx_r + LW'(1);
            state_nxt = S_CREAD;
          end
        end else if (c == CH_AND || c == CH_XOR || c == CH_OR) begin
          if (want_r) begin
            err_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_CBIN;
          end
        end else if (c == CH_RPAR) begin
          if (want_r || depth_r == '0) begin
            err_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_CRPAR;
          end
        end else begin
          err_nxt   = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_CBIN: begin
        if (top_r != '0 && prec(op_rd_r) >= prec(cur_r)) begin
          post_we    = 1'b1;
          post_wdata = op_rd_r;
          n_nxt      = n_r + LW'(1);
          top_nxt    = top_r - LW'(1);
          ret_nxt    = S_CBIN;
          state_nxt  = S_WAIT;
        end else if (top_r >= LW'(MAX_LEN)) begin
          err_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          op_we     = 1'b1;
          op_wdata  = cur_r;
          top_nxt   = top_r + LW'(1);
          want_nxt  = 1'b1;
          idx_nxt   = idx_r + LW'(1);
          state_nxt = S_CREAD;
        end
      end
      S_CRPAR: begin
        if (top_r != '0 && op_rd_r != CH_LPAR) begin
          post_we    = 1'b1;
          post_wdata = op_rd_r;
          n_nxt      = n_r + LW'(1);
          top_nxt    = top_r - LW'(1);
          ret_nxt    = S_CRPAR;
          state_nxt  = S_WAIT;
        end else begin
          if (top_r != '0) top_nxt = top_r - LW'(1);
          depth_nxt = depth_r - LW'(1);
          idx_nxt   = idx_r + LW'(1);
          state_nxt = S_CREAD;
        end
      end
      S_CEND: begin
        if (want_r || depth_r != '0) begin
          err_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (top_r != '0) begin
          post_we    = 1'b1;
          post_wdata = op_rd_r;
          n_nxt      = n_r + LW'(1);
          top_nxt    = top_r - LW'(1);
          ret_nxt    = S_CEND;
          state_nxt  = S_WAIT;
        end else if (!sel_r) begin
          plen0_nxt = n_r;
          sel_nxt   = 1'b1;
          idx_nxt   = '0;
          top_nxt   = '0;
          depth_nxt = '0;
          n_nxt     = '0;
          want_nxt  = 1'b1;
          state_nxt = S_CREAD;
        end else begin
          plen1_nxt = n_r;
          k_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = S_RANK;
        end
      end
      S_WAIT: begin
        // The stack reads are registered, so wait here until they follow the moved top.
        state_nxt = ret_r;
      end
      S_RANK: begin
        rank_we = 1'b1;
        if (mask_r[k_r[VW-1:0]]) cnt_nxt = cnt_r + RW'(1);
        if (k_r == RW'(NUM_VARS - 1)) begin
          asg_nxt   = '0;
          sel_nxt   = 1'b0;
          idx_nxt   = '0;
          sp_nxt    = '0;
          state_nxt = S_EREAD;
        end else begin
          k_nxt = k_r + RW'(1);
        end
      end
      S_EREAD: begin
        state_nxt = (idx_r == cur_plen) ? S_EDONE : S_ETOK;
      end
      S_ETOK: begin
        idx_nxt   = idx_r + LW'(1);
        state_nxt = S_EREAD;
        if (c_opnd) begin
          if (sp_r != '0) vs_we = 1'b1;
          tv_nxt = opnd_val;
          sp_nxt = sp_r + LW'(1);
        end else if (c == CH_NOT) begin
          tv_nxt = !tv_r;
        end else begin
          sp_nxt = sp_r - LW'(1);
          if (c == CH_AND)      tv_nxt = vs_rd_r & tv_r;
          else if (c == CH_XOR) tv_nxt = vs_rd_r ^ tv_r;
          else                  tv_nxt = vs_rd_r | tv_r;
        end
      end
      S_EDONE: begin
        idx_nxt = '0;
        sp_nxt  = '0;
        if (!sel_r) begin
          res0_nxt  = tv_r;
          sel_nxt   = 1'b1;
          state_nxt = S_EREAD;
        end else if (tv_r != res0_r) begin
          eq_nxt    = 1'b0;
          state_nxt = S_FIN;
        end else if (CW'(asg_r + CW'(1)) == (CW'(1) << cnt_r)) begin
          eq_nxt    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          asg_nxt   = asg_r + CW'(1);
          sel_nxt   = 1'b0;
          state_nxt = S_EREAD;
        end
      end
      S_FIN: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      mask_r  <= '0;
      asg_r   <= '0;
      err_r   <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      mask_r  <= mask_nxt;
      asg_r   <= asg_nxt;
      err_r   <= err_nxt;
      eq_r    <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r   <= sel_nxt;
    idx_r   <= idx_nxt;
    top_r   <= top_nxt;
    depth_r <= depth_nxt;
    n_r     <= n_nxt;
    sp_r    <= sp_nxt;
    plen0_r <= plen0_nxt;
    plen1_r <= plen1_nxt;
    want_r  <= want_nxt;
    cur_r   <= cur_nxt;
    k_r     <= k_nxt;
    cnt_r   <= cnt_nxt;
    tv_r    <= tv_nxt;
    res0_r  <= res0_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign res.equivalent     = !err_r && eq_r;
  assign res.error          = err_r;
  assign res.variable_count = err_r ? 5'd0 : 5'(cnt_r);

endmodule

// ----- rtl/bee_out_q.sv -----
// ----------------------------------------------------------------------------
// Result queue
// Two-entry queue that holds finished results until they are taken.
// ----------------------------------------------------------------------------
module bee_out_q import bee_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t din,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output out_item_t dout
);

  out_item_t  slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ----- rtl/boolean_expression_equivalence_unit.sv -----
// ----------------------------------------------------------------------------
// Boolean expression equivalence unit
// Loads two infix boolean expressions and checks them for equivalence.
// ----------------------------------------------------------------------------
// Input channel: push/full with in_item. Clear and append commands give
// no result. A run command gives one result on the out channel (empty/pop
// with out_item).
// While a run is in progress full stays high. Conversion reads each
// character, goes through an extra state per binary operator and closing
// parenthesis, pops the operator stack through a wait state and flushes it
// at the end of each text; then a rank pass over all NUM_VARS variable slots
// numbers the used variables. The walk then evaluates every postfix token of
// both expressions for every assignment tried, up to 2^count assignments; a
// mismatch ends the walk early. The walk reads the postfix store through a register.
// Results wait in a two-entry queue; while it is full a finished run holds
// and the input stays blocked. Reset clears both texts, the error flag and
// the queue; the text memories need no clearing pass.
// ----------------------------------------------------------------------------
module boolean_expression_equivalence_unit import bee_pkg::*; #(
  parameter int MAX_LEN  = 128,
  parameter int NUM_VARS = 26
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  logic          acc, start, ovf, busy;
  logic          txt_sel;
  logic [AW-1:0] txt_addr;
  logic [7:0]    txt_data;
  logic [LW-1:0] len1, len2;
  logic          res_push, res_full;
  out_item_t     res;

  assign in_full = busy;
  assign acc     = in_push && !in_full;

  bee_front #(.MAX_LEN(MAX_LEN), .AW(AW), .LW(LW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .item    (in_item),
    .rd_sel  (txt_sel),
    .rd_addr (txt_addr),
    .rd_data (txt_data),
    .len1    (len1),
    .len2    (len2),
    .ovf     (ovf),
    .start   (start)
  );

  bee_back #(.MAX_LEN(MAX_LEN), .NUM_VARS(NUM_VARS), .AW(AW), .LW(LW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .ovf      (ovf),
    .len1     (len1),
    .len2     (len2),
    .txt_sel  (txt_sel),
    .txt_addr (txt_addr),
    .txt_data (txt_data),
    .busy     (busy),
    .res_push (res_push),
    .res_full (res_full),
    .res      (res)
  );

  bee_out_q u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (out_item)
  );

endmodule

// ----- tb/tb_boolean_expression_equivalence_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boolean expression equivalence unit testbench
// Streams clear, append and run commands into the unit with random gaps on
// both queues. Each run's outcome is predicted by converting both texts to
// postfix and evaluating them over every variable assignment, then checked
// field by field against the popped results.
// ----------------------------------------------------------------------------
module tb_boolean_expression_equivalence_unit;
  import bee_pkg::*;

  typedef logic [7:0] sym_t;
  typedef sym_t sym_q_t[$];
  typedef struct {
    in_item_t cmd;
    bit       drain;
  } cmd_entry_t;

  localparam int TEXT_CAP  = 128;
  localparam int STALL_CAP = 500000;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;

  cmd_entry_t cmd_pending[$];
  out_item_t  verdicts_due[$];

  sym_q_t    text_one;
  sym_q_t    text_two;
  bit        text_overflowed;
  int        mismatches;
  int        stall_cycles;
  bit        cmd_taken;
  int        in_gap;
  int        out_gap;
  bit        calm;

  boolean_expression_equivalence_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  function automatic bit is_letter(sym_t c);
    return c >= CH_A && c <= 8'h7A;
  endfunction

  function automatic bit is_operand(sym_t c);
    return is_letter(c) || c == CH_ZERO || c == CH_ONE;
  endfunction

  function automatic int binding(sym_t c);
    case (c)
      CH_NOT:  return 4;
      CH_AND:  return 3;
      CH_XOR:  return 2;
      CH_OR:   return 1;
      default: return 0;
    endcase
  endfunction

  // Returns 1 when the text is malformed; otherwise fills the postfix queue.
  function automatic bit infix_to_postfix(input sym_q_t txt, output sym_q_t rpn,
                                          inout logic [25:0] used);
    sym_q_t ops;
    bit     need_operand;
    int     depth;
    sym_t   c;
    need_operand = 1;
    depth = 0;
    rpn = {};
    foreach (txt[i]) begin
      c = txt[i];
      if (is_operand(c)) begin
        if (!need_operand) return 1;
        if (is_letter(c)) used[c - CH_A] = 1'b1;
        rpn.push_back(c);
        need_operand = 0;
      end else if (c == CH_LPAR || c == CH_NOT) begin
        if (!need_operand) return 1;
        if (c == CH_LPAR) depth++;
        ops.push_back(c);
      end else if (c == CH_AND || c == CH_XOR || c == CH_OR) begin
        if (need_operand) return 1;
        while (ops.size() > 0 && binding(ops[$]) >= binding(c)) rpn.push_back(ops.pop_back());
        ops.push_back(c);
        need_operand = 1;
      end else if (c == CH_RPAR) begin
        if (need_operand || depth == 0) return 1;
        while (ops.size() > 0 && ops[$] != CH_LPAR) rpn.push_back(ops.pop_back());
        if (ops.size() > 0) void'(ops.pop_back());
        depth--;
      end else begin
        return 1;
      end
    end
    if (need_operand || depth != 0) return 1;
    while (ops.size() > 0) rpn.push_back(ops.pop_back());
    return 0;
  endfunction

  function automatic bit eval_postfix(input sym_q_t rpn, input logic [25:0] values);
    bit stk[$];
    bit rhs;
    foreach (rpn[i]) begin
      if (is_letter(rpn[i])) stk.push_back(values[rpn[i] - CH_A]);
      else if (rpn[i] == CH_ZERO) stk.push_back(1'b0);
      else if (rpn[i] == CH_ONE) stk.push_back(1'b1);
      else if (rpn[i] == CH_NOT) begin
        if (stk.size() > 0) stk[$] = !stk[$];
      end else if (stk.size() >= 2) begin
        rhs = stk.pop_back();
        if (rpn[i] == CH_AND) stk[$] = stk[$] & rhs;
        else if (rpn[i] == CH_XOR) stk[$] = stk[$] ^ rhs;
        else stk[$] = stk[$] | rhs;
      end
    end
    return stk.size() > 0 ? stk[0] : 1'b0;
  endfunction

  function automatic out_item_t judge_texts();
    out_item_t     verdict;
    sym_q_t        rpn_one, rpn_two;
    logic [25:0]   used, values;
    bit            bad;
    int            count, pos;
    longint        idx;
    verdict = '0;
    used = '0;
    bad = text_overflowed;
    if (!bad) bad = infix_to_postfix(text_one, rpn_one, used);
    if (!bad) bad = infix_to_postfix(text_two, rpn_two, used);
    if (bad) begin
      verdict.error = 1'b1;
      return verdict;
    end
    count = $countones(used);
    verdict.variable_count = 5'(count);
    verdict.equivalent = 1'b1;
    // The k-th used letter in alphabetical order takes bit k of the index.
    for (idx = 0; idx < (64'd1 << count); idx++) begin
      values = '0;
      pos = 0;
      for (int k = 0; k < 26; k++) begin
        if (used[k]) begin
          values[k] = idx[pos];
          pos++;
        end
      end
      if (eval_postfix(rpn_one, values) != eval_postfix(rpn_two, values)) begin
        verdict.equivalent = 1'b0;
        break;
      end
    end
    return verdict;
  endfunction

  function automatic void apply_command(in_item_t cmd);
    case (cmd.operation)
      OP_CLEAR: begin
        text_one = {};
        text_two = {};
        text_overflowed = 0;
      end
      OP_APPEND1: begin
        if (text_one.size() < TEXT_CAP) text_one.push_back(cmd.symbol);
        else text_overflowed = 1;
      end
      OP_APPEND2: begin
        if (text_two.size() < TEXT_CAP) text_two.push_back(cmd.symbol);
        else text_overflowed = 1;
      end
      default: verdicts_due.push_back(judge_texts());
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_cmd(logic [1:0] op, sym_t sym, bit drain = 0);
    cmd_entry_t e;
    e.cmd.operation = op;
    e.cmd.symbol = sym;
    e.drain = drain;
    cmd_pending.push_back(e);
  endtask

  task automatic queue_text(logic [1:0] op, string s);
    for (int i = 0; i < s.len(); i++) queue_cmd(op, sym_t'(s[i]));
  endtask

  task automatic queue_pair(string s1, string s2);
    queue_cmd(OP_CLEAR, 8'h00);
    queue_text(OP_APPEND1, s1);
    queue_text(OP_APPEND2, s2);
    queue_cmd(OP_RUN, 8'h00);
  endtask

  function automatic string random_expr(int depth, int base, int nv);
    string t, l, r;
    int    w;
    if (depth == 0 || $urandom_range(0, 2) == 0) begin
      w = $urandom_range(0, 99);
      if (w < 85) t = $sformatf("%c", 8'h61 + base + $urandom_range(0, nv - 1));
      else t = (w < 92) ? "0" : "1";
      if ($urandom_range(0, 4) == 0) t = {"~", t};
      return t;
    end
    l = random_expr(depth - 1, base, nv);
    r = random_expr(depth - 1, base, nv);
    case ($urandom_range(0, 2))
      0:       t = {l, "&", r};
      1:       t = {l, "^", r};
      default: t = {l, "|", r};
    endcase
    w = $urandom_range(0, 9);
    if (w < 3) t = {"(", t, ")"};
    else if (w == 3) t = {"~(", t, ")"};
    return t;
  endfunction

  function automatic string same_meaning(string e);
    case ($urandom_range(0, 5))
      0:       return e;
      1:       return {"~~(", e, ")"};
      2:       return {"(", e, ")&1"};
      3:       return {"0|(", e, ")"};
      4:       return {"(", e, ")^0"};
      default: return {"(", e, ")&(", e, ")"};
    endcase
  endfunction

  // Transfers are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      stall_cycles = stall_cycles + 1;
      if (in_push && !in_full) begin
        apply_command(in_item);
        void'(cmd_pending.pop_front());
        cmd_taken = 1;
        stall_cycles = 0;
      end
      if (out_pop && !out_empty) begin
        stall_cycles = 0;
        out_gap = pick_gap();
        if (verdicts_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_item);
        end else if (verdicts_due[0] !== out_item) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected eq=%0b err=%0b vars=%0d, got eq=%0b err=%0b vars=%0d",
                     verdicts_due[0].equivalent, verdicts_due[0].error,
                     verdicts_due[0].variable_count, out_item.equivalent, out_item.error,
                     out_item.variable_count);
          void'(verdicts_due.pop_front());
        end else begin
          void'(verdicts_due.pop_front());
        end
      end
      if ($urandom_range(0, 299) == 0) calm = !calm;
      if (stall_cycles >= STALL_CAP) begin
        $display("tb_boolean_expression_equivalence_unit NOT OK");
        $finish;
      end
    end
  end

  // Command driver and result consumer, both updated at the falling edge.
  always @(negedge clk) begin
    logic     nxt_push;
    in_item_t nxt_item;
    nxt_push = in_push;
    nxt_item = in_item;
    if (rst_n) begin
      if (cmd_taken) begin
        cmd_taken = 0;
        nxt_push = 1'b0;
        in_gap = pick_gap();
      end
      if (!nxt_push) begin
        if (in_gap > 0) in_gap--;
        else if (cmd_pending.size() > 0 &&
                 !(cmd_pending[0].drain && verdicts_due.size() > 0)) begin
          nxt_push = 1'b1;
          nxt_item = cmd_pending[0].cmd;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
    in_push <= nxt_push;
    in_item <= nxt_item;
  end

  initial begin
    string e1, e2;
    int    base, nv, depth;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    out_pop = 1'b0;
    text_overflowed = 0;
    mismatches = 0;
    stall_cycles = 0;
    cmd_taken = 0;
    in_gap = 0;
    out_gap = 0;
    calm = 0;

    // Directed: empty texts, precedence, constants, all 26 letters, bad input.
    queue_cmd(OP_RUN, 8'h00);
    queue_pair("a", "a");
    queue_pair("~(a&b)", "~a|~b");
    queue_pair("a^b", "(a|b)&~(a&b)");
    queue_pair("a|b&c", "a|(b&c)");
    queue_pair("a^b&c", "(a^b)&c");
    queue_pair("1", "~0");
    queue_pair("1&0", "1");
    queue_pair("a|b|c|d|e|f|g|h|i|j|k|l|m|n|o|p|q|r|s|t|u|v|w|x|y|z", "a&b");
    queue_pair("a b", "a");
    queue_pair("A", "a");
    queue_pair("a", "{");
    queue_pair("a&", "a");
    queue_pair("(a", "a");
    queue_pair("a)", "a");
    queue_pair("ab", "a");
    queue_pair("a", "()");
    queue_cmd(OP_RUN, 8'h00);
    queue_cmd(OP_CLEAR, 8'h00);
    for (int i = 0; i < TEXT_CAP + 2; i++) queue_cmd(OP_APPEND1, CH_A);
    queue_text(OP_APPEND2, "a");
    queue_cmd(OP_RUN, 8'h00);
    queue_pair("z", "z");
    queue_cmd(OP_RUN, 8'h00, 1);

    while (cmd_pending.size() < 1850) begin
      base = $urandom_range(0, 20);
      nv = $urandom_range(1, 6);
      depth = $urandom_range(1, 3);
      e1 = random_expr(depth, base, nv);
      e2 = ($urandom_range(0, 1) == 0) ? same_meaning(e1) : random_expr(depth, base, nv);
      if ($urandom_range(0, 7) == 0 && e2.len() > 1) e2 = e2.substr(0, e2.len() - 2);
      if ($urandom_range(0, 11) != 0) queue_cmd(OP_CLEAR, 8'($urandom_range(0, 255)));
      queue_text(OP_APPEND1, e1);
      queue_text(OP_APPEND2, e2);
      if ($urandom_range(0, 7) == 0)
        queue_cmd($urandom_range(0, 1) ? OP_APPEND1 : OP_APPEND2, 8'($urandom_range(0, 255)));
      queue_cmd(OP_RUN, 8'($urandom_range(0, 255)), $urandom_range(0, 40) == 0);
      if ($urandom_range(0, 9) == 0) queue_cmd(OP_RUN, 8'h00);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (cmd_pending.size() > 0 || verdicts_due.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("tb_boolean_expression_equivalence_unit OK");
    end else begin
      $display("tb_boolean_expression_equivalence_unit NOT OK");
    end
    $finish;
  end

endmodule
